// ===== src/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam logic [15:0] SUR_LO    = 16'hD800;
    localparam logic [15:0] LEAD_HI   = 16'hDBFF;
    localparam logic [15:0] TAIL_LO   = 16'hDC00;
    localparam logic [15:0] SUR_HI    = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] MAX_1B    = 21'h00007F;
    localparam logic [20:0] MAX_2B    = 21'h0007FF;
    localparam logic [20:0] MAX_3B    = 21'h00FFFF;
    localparam logic [7:0]  LEAD_2B   = 8'hC0;
    localparam logic [7:0]  LEAD_3B   = 8'hE0;
    localparam logic [7:0]  LEAD_4B   = 8'hF0;
    localparam logic [7:0]  CONT_B    = 8'h80;
    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_BAD   = 1'b1;

    typedef struct packed {
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            summary;
        logic [15:0]     count;
        logic            status;
    } bundle_t;

endpackage

// ===== src/u16u8_step.sv =====
// ----------------------------------------------------------------------------
// u16u8_step
// Input register, per-string state and single-pass decode of one code unit
// into a bundle of up to four UTF-8 bytes and an optional summary.
// ----------------------------------------------------------------------------
module u16u8_step
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_unit,
    input  logic        in_last,
    input  logic        emit_free,
    output logic        bundle_load,
    output bundle_t     bundle
);

    logic        in_valid_reg;
    logic [15:0] unit_reg;
    logic        last_reg;
    logic [15:0] capacity_reg;
    logic [9:0]  pending_lead_reg, pending_lead_next;
    logic        lead_valid_reg, lead_valid_next;
    logic [15:0] bytes_written_reg, bytes_written_next;
    logic        halted_reg, halted_next;
    logic        error_seen_reg, error_seen_next;

    logic        in_move;
    logic        bundle_empty;
    logic [15:0] usable;
    logic        do_enc;
    logic [20:0] cp;
    logic [2:0]  n;
    logic        fit;
    logic [3:0][7:0] enc_bytes;

    assign usable = (capacity_reg == 16'd0) ? 16'd0 : capacity_reg - 16'd1;

    always_comb
    begin
        if (cp <= MAX_1B)
        begin
            n = 3'd1;
        end
        else if (cp <= MAX_2B)
        begin
            n = 3'd2;
        end
        else if (cp <= MAX_3B)
        begin
            n = 3'd3;
        end
        else
        begin
            n = 3'd4;
        end
    end

    assign fit = ({1'b0, bytes_written_reg} + {14'd0, n}) <= {1'b0, usable};

    always_comb
    begin
        enc_bytes = '0;
        case (n)
            3'd1:
            begin
                enc_bytes[0] = cp[7:0];
            end
            3'd2:
            begin
                enc_bytes[0] = LEAD_2B | {3'd0, cp[10:6]};
                enc_bytes[1] = CONT_B | {2'd0, cp[5:0]};
            end
            3'd3:
            begin
                enc_bytes[0] = LEAD_3B | {4'd0, cp[15:12]};
                enc_bytes[1] = CONT_B | {2'd0, cp[11:6]};
                enc_bytes[2] = CONT_B | {2'd0, cp[5:0]};
            end
            default:
            begin
                enc_bytes[0] = LEAD_4B | {5'd0, cp[20:18]};
                enc_bytes[1] = CONT_B | {2'd0, cp[17:12]};
                enc_bytes[2] = CONT_B | {2'd0, cp[11:6]};
                enc_bytes[3] = CONT_B | {2'd0, cp[5:0]};
            end
        endcase
    end

    always_comb
    begin
        pending_lead_next  = pending_lead_reg;
        lead_valid_next    = lead_valid_reg;
        bytes_written_next = bytes_written_reg;
        halted_next        = halted_reg;
        error_seen_next    = error_seen_reg;
        do_enc             = 1'b0;
        cp                 = {5'd0, unit_reg};
        bundle             = '0;

        if (!halted_reg && !error_seen_reg)
        begin
            if (lead_valid_reg)
            begin
                lead_valid_next = 1'b0;
                if (unit_reg >= TAIL_LO && unit_reg <= SUR_HI)
                begin
                    cp     = SUPP_BASE + {1'b0, pending_lead_reg, unit_reg[9:0]};
                    do_enc = 1'b1;
                end
                else
                begin
                    error_seen_next = 1'b1;
                end
            end
            else if (bytes_written_reg >= usable)
            begin
                halted_next = 1'b1;
            end
            else if (unit_reg < SUR_LO || unit_reg > SUR_HI)
            begin
                do_enc = 1'b1;
            end
            else if (unit_reg > LEAD_HI)
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                pending_lead_next = unit_reg[9:0];
                lead_valid_next   = 1'b1;
            end
        end

        if (do_enc)
        begin
            if (fit)
            begin
                bundle.nbytes      = n;
                bundle.bytes       = enc_bytes;
                bytes_written_next = bytes_written_reg + {13'd0, n};
            end
            else
            begin
                halted_next = 1'b1;
            end
        end

        if (last_reg)
        begin
            if (lead_valid_next)
            begin
                error_seen_next = 1'b1;
            end
            bundle.summary     = 1'b1;
            bundle.status      = error_seen_next ? STATUS_BAD : STATUS_OK;
            bundle.count       = error_seen_next ? 16'd0 : bytes_written_next;
            pending_lead_next  = '0;
            lead_valid_next    = 1'b0;
            bytes_written_next = '0;
            halted_next        = 1'b0;
            error_seen_next    = 1'b0;
        end
    end

    assign bundle_empty = (bundle.nbytes == 3'd0) && !bundle.summary;
    assign in_move      = in_valid_reg && (bundle_empty || emit_free);
    assign bundle_load  = in_move && !bundle_empty;
    assign in_ready     = !in_valid_reg || in_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            capacity_reg      <= CAP_RESET;
            pending_lead_reg  <= '0;
            lead_valid_reg    <= 1'b0;
            bytes_written_reg <= '0;
            halted_reg        <= 1'b0;
            error_seen_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (in_move)
            begin
                pending_lead_reg  <= pending_lead_next;
                lead_valid_reg    <= lead_valid_next;
                bytes_written_reg <= bytes_written_next;
                halted_reg        <= halted_next;
                error_seen_reg    <= error_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            unit_reg <= in_unit;
            last_reg <= in_last;
        end
    end

endmodule

// ===== src/u16u8_emit.sv =====
// ----------------------------------------------------------------------------
// u16u8_emit
// Result register holding one bundle; sends its bytes and summary one
// transfer per cycle on the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module u16u8_emit
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bundle_t     bundle_in,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data,
    output logic        out_user,
    output logic        out_last
);

    logic       bvalid_reg;
    logic [2:0] idx_reg;
    bundle_t    bundle_reg;
    logic       at_summary;
    logic       xfer;

    assign at_summary = (idx_reg == bundle_reg.nbytes);
    assign out_valid  = bvalid_reg;
    assign out_user   = at_summary ? KIND_SUMMARY : KIND_DATA;
    assign out_last   = bundle_reg.summary ? at_summary
                                           : ((idx_reg + 3'd1) == bundle_reg.nbytes);
    assign out_data   = at_summary
                      ? {7'd0, bundle_reg.status, bundle_reg.count, 8'd0}
                      : {7'd0, STATUS_OK, 16'd0, bundle_reg.bytes[idx_reg[1:0]]};
    assign xfer       = bvalid_reg && out_ready;
    assign free       = !bvalid_reg || (xfer && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            bvalid_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (xfer && out_last)
        begin
            bvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

// ===== src/utf16_to_utf8_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// UTF-16 code units in, UTF-8 bytes and an end-of-string summary out.
//
// Input stream: one code unit per transfer, tlast on the final unit.
// Output stream: tuser 0 carries a UTF-8 byte, tuser 1 the summary with
// byte count and status; tlast marks the last result of an input unit.
// Output is limited to capacity - 1 bytes; a character that does not fit
// ends the string quietly. On status 1 the count is zero and bytes already
// sent for the string are to be dropped.
// Each unit passes the input register, then its results the output register.
// Throughput with m_axis_tready high: one result per cycle, set by the single
// output register; a unit yielding no result or one result is taken every
// cycle, a unit yielding k results (up to 5) holds the output until all sent.
// Reset clears the string state and sets capacity to 256.
// If the receiver stalls, the held result stays put, the next unit yielding
// results is decoded and waits in the input register, then tready falls.
// The user writes capacity via cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_count, [24] status
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast
);

    logic    emit_free;
    logic    bundle_load;
    bundle_t bundle;

    u16u8_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_unit     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .emit_free   (emit_free),
        .bundle_load (bundle_load),
        .bundle      (bundle)
    );

    u16u8_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (bundle_load),
        .bundle_in (bundle),
        .free      (emit_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // summary always closes the results of its unit
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SUMMARY) |-> m_axis_tlast)
        else $error("summary without tlast");

    // failed string reports a zero count
    a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SUMMARY && m_axis_tdata[24] == STATUS_BAD)
        |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("error summary with non-zero count");

    // data bytes carry no count or status
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> (m_axis_tdata[31:8] == 24'd0))
        else $error("data byte with summary fields set");

    // a bundle is only loaded when the result register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_load |-> emit_free)
        else $error("result register overwritten");

endmodule
